@@ rtl/teba_pkg.sv @@
// shared types, constants and helpers of the two-ended bump allocator
package teba_pkg;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 25;
    localparam int FREE_W     = 25;
    localparam int ALIGN_W    = 7;
    localparam int CMD_W      = 3;
    localparam int RSIZE_W    = SIZE_W + 1;
    localparam int CHARGE_W   = ADDR_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 64;

    localparam int POINTER_BYTES = 4;
    localparam int MIN_ALIGN     = 4;
    localparam int MIN_SIZE      = 4;

    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_HEAD      = 3'd0,
        CMD_TAIL      = 3'd1,
        CMD_FREE_ALL  = 3'd2,
        CMD_FREE_TAIL = 3'd3,
        CMD_QUERY     = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS = 2'd0,
        REG_HEAP_SIZE    = 2'd1,
        REG_ERR_ENABLE   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_CHARGE,
        ST_COMMIT
    } state_t;

    // step strobes from the controller to the datapath
    typedef struct packed {
        logic load;
        logic addr;
        logic charge;
        logic commit;
    } dp_cmd_t;

    // size rounded up to the minimum and to pointer size
    function automatic logic [RSIZE_W-1:0] round_size(input logic [SIZE_W-1:0] raw);
        logic [RSIZE_W-1:0] s;
        s = {1'b0, raw};
        if (s < RSIZE_W'(MIN_SIZE)) begin
            s = RSIZE_W'(MIN_SIZE);
        end
        return (s + RSIZE_W'(POINTER_BYTES - 1)) & ~RSIZE_W'(POINTER_BYTES - 1);
    endfunction

    // alignment mask: highest set bit of the request, at least the minimum alignment
    function automatic logic [ALIGN_W-1:0] align_mask(input logic [ALIGN_W-1:0] raw);
        logic [ALIGN_W-1:0] a;
        a = '0;
        for (int b = 0; b < ALIGN_W; b++) begin
            if (raw[b]) begin
                a = ALIGN_W'(1) << b;
            end
        end
        if (a < ALIGN_W'(MIN_ALIGN)) begin
            a = ALIGN_W'(MIN_ALIGN);
        end
        return a - ALIGN_W'(1);
    endfunction

endpackage

@@ rtl/teba_dp.sv @@
// datapath: configuration, pointers, free count, step registers and result word
module teba_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [teba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [teba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [teba_pkg::S_DATA_W-1:0]     s_tdata,
    input  teba_pkg::dp_cmd_t                 cmd,
    output logic [teba_pkg::M_DATA_W-1:0]     m_tdata
);
    import teba_pkg::*;

    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [FREE_W-1:0]   heap_reg, heap_next;
    logic                err_en_reg, err_en_next;

    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [ADDR_W-1:0]   tail_reg, tail_next;
    logic [FREE_W-1:0]   free_reg, free_next;

    cmd_t                op_reg, op_next;
    logic [RSIZE_W-1:0]  size_reg, size_next;
    logic [ALIGN_W-1:0]  mask_reg, mask_next;
    logic [ADDR_W-1:0]   start_reg, start_next;
    logic [CHARGE_W-1:0] charge_reg, charge_next;

    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic                out_ok_reg, out_ok_next;
    logic                out_hcall_reg, out_hcall_next;
    logic [FREE_W-1:0]   out_free_reg, out_free_next;

    logic [ADDR_W-1:0]   wide_mask;
    logic                fits;

    // pointer distances, wrapping modulo 2^32
    logic [ADDR_W-1:0]   head_gap;
    logic [ADDR_W-1:0]   tail_gap;
    logic [ADDR_W-1:0]   end_gap;

    assign wide_mask = ADDR_W'(mask_reg);
    assign fits      = charge_reg <= CHARGE_W'(free_reg);
    assign head_gap  = start_reg - head_reg;
    assign tail_gap  = tail_reg - start_reg;
    assign end_gap   = start_reg - tail_reg;

    always_comb begin
        base_next      = base_reg;
        heap_next      = heap_reg;
        err_en_next    = err_en_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_next      = free_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        mask_next      = mask_reg;
        start_next     = start_reg;
        charge_next    = charge_reg;
        out_addr_next  = out_addr_reg;
        out_ok_next    = out_ok_reg;
        out_hcall_next = out_hcall_reg;
        out_free_next  = out_free_reg;

        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_BASE_ADDRESS: base_next   = cfg_wdata[ADDR_W-1:0];
                REG_HEAP_SIZE:    heap_next   = cfg_wdata[FREE_W-1:0];
                REG_ERR_ENABLE:   err_en_next = cfg_wdata[0];
                default:          ;
            endcase
        end

        if (cmd.load) begin
            op_next   = cmd_t'(s_tdata[CMD_W-1:0]);
            size_next = round_size(s_tdata[CMD_W +: SIZE_W]);
            mask_next = align_mask(s_tdata[CMD_W+SIZE_W +: ALIGN_W]);
        end

        // first step: aligned start address, or the region end
        if (cmd.addr) begin
            case (op_reg)
                CMD_HEAD: start_next = (head_reg + wide_mask) & ~wide_mask;
                CMD_TAIL: start_next = (tail_reg - ADDR_W'(size_reg)) & ~wide_mask;
                default:  start_next = base_reg + ADDR_W'(heap_reg);
            endcase
        end

        // second step: bytes charged, or the reclaimed total for free tail
        if (cmd.charge) begin
            case (op_reg)
                CMD_HEAD:
                    charge_next = CHARGE_W'(size_reg) + CHARGE_W'(head_gap);
                CMD_TAIL:
                    charge_next = CHARGE_W'(tail_gap);
                default:
                    charge_next = CHARGE_W'(free_reg) + CHARGE_W'(end_gap);
            endcase
        end

        if (cmd.commit) begin
            out_addr_next  = '0;
            out_ok_next    = 1'b0;
            out_hcall_next = 1'b0;
            case (op_reg)
                CMD_HEAD, CMD_TAIL: begin
                    if (fits) begin
                        out_addr_next = start_reg;
                        out_ok_next   = 1'b1;
                        free_next     = free_reg - FREE_W'(charge_reg);
                        if (op_reg == CMD_HEAD) begin
                            head_next = head_reg + charge_reg[ADDR_W-1:0];
                        end else begin
                            tail_next = start_reg;
                        end
                    end else begin
                        out_hcall_next = err_en_reg;
                    end
                end
                CMD_FREE_ALL: begin
                    head_next   = base_reg;
                    tail_next   = start_reg;
                    free_next   = heap_reg;
                    out_ok_next = 1'b1;
                end
                CMD_FREE_TAIL: begin
                    // total saturates at the largest count
                    if (charge_reg > CHARGE_W'(FREE_MAX)) begin
                        free_next = FREE_MAX;
                    end else begin
                        free_next = charge_reg[FREE_W-1:0];
                    end
                    tail_next   = start_reg;
                    out_ok_next = 1'b1;
                end
                CMD_QUERY: out_ok_next = 1'b1;
                default:   ;
            endcase
            out_free_next = free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            heap_reg   <= '0;
            err_en_reg <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= '0;
        end else begin
            base_reg   <= base_next;
            heap_reg   <= heap_next;
            err_en_reg <= err_en_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        size_reg      <= size_next;
        mask_reg      <= mask_next;
        start_reg     <= start_next;
        charge_reg    <= charge_next;
        out_addr_reg  <= out_addr_next;
        out_ok_reg    <= out_ok_next;
        out_hcall_reg <= out_hcall_next;
        out_free_reg  <= out_free_next;
    end

    assign m_tdata = {(M_DATA_W - ADDR_W - 2 - FREE_W)'(0), out_free_reg,
                      out_hcall_reg, out_ok_reg, out_addr_reg};

endmodule

@@ rtl/teba_ctrl.sv @@
// controller: request sequencing and result word handshake
module teba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output teba_pkg::dp_cmd_t cmd
);
    import teba_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_CHARGE;
            ST_CHARGE: state_next = ST_COMMIT;
            ST_COMMIT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_ADDR:   cmd.addr   = 1'b1;
            ST_CHARGE: cmd.charge = 1'b1;
            ST_COMMIT: cmd.commit = out_free;
            default:   ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_commit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    a_load_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_ADDR)
        else $error("accepted word did not start the sequence");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    a_one_step_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.addr, cmd.charge, cmd.commit}))
        else $error("datapath steps overlap");

endmodule

@@ rtl/two_ended_bump_allocator_top.sv @@
// two-ended bump allocator: top level joining controller and datapath
// a result word is registered and made valid by the commit step, which waits while the
//   previous result is still held; each request takes the accept, align, charge and commit
//   steps through the single datapath before the next request is accepted
// a request may be accepted while the previous result still waits on m_tready
// reset: synchronous active-low aresetn clears config, pointers and free count to 0;
//   software writes the config and then issues free all
module two_ended_bump_allocator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [teba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [teba_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // command[2:0], alloc_size[27:3], align_bytes[34:28], zero fill above
    input  logic [teba_pkg::S_DATA_W-1:0]     s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // block_address[31:0], success[32], handler_call[33], free_bytes[58:34], zero fill above
    output logic [teba_pkg::M_DATA_W-1:0]     m_tdata
);
    import teba_pkg::*;

    // step strobes from controller to datapath
    dp_cmd_t cmd;

    // sequencer: accepts a word, walks the datapath steps, owns the result valid
    teba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // arithmetic and all architectural state, including the result register
    teba_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tdata   (m_tdata)
    );

endmodule
